// ===== hw/rtl/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list engine: command codes,
// result status codes and the operation that is broadcast to the cell chain.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_DUMP_FWD = 3'd4,
    CMD_DUMP_REV = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // Operation applied by every cell of the chain together.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

// ===== hw/rtl/plist_cell.sv =====
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. Holds a value and, as the broadcast operation says, keeps it,
// takes the neighbor on either side or takes the feed value.
// ----------------------------------------------------------------------------
module plist_cell
  import plist_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                       clk,
  input  cell_op_t                   op,
  input  logic [IW-1:0]              tgt,
  input  logic [IW-1:0]              tail,
  input  logic signed [VALUE_W-1:0]  feed,
  input  logic signed [VALUE_W-1:0]  left_val,
  input  logic signed [VALUE_W-1:0]  right_val,
  output logic signed [VALUE_W-1:0]  value
);

  localparam logic [IW-1:0] IDX_I = IW'(IDX);

  logic signed [VALUE_W-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (op)
      CELL_INSERT: begin
        if (IDX_I > tgt) begin
          value_next = left_val;
        end else if (IDX_I == tgt) begin
          value_next = feed;
        end
      end
      CELL_DELETE: begin
        if (IDX_I >= tgt) begin
          value_next = right_val;
        end
      end
      CELL_ROT_LEFT: begin
        // The head wraps around to the tail slot.
        if (IDX_I == tail) begin
          value_next = feed;
        end else if (IDX_I < tail) begin
          value_next = right_val;
        end
      end
      CELL_ROT_RIGHT: begin
        // The tail wraps around to the head slot.
        if (IDX_I == '0) begin
          value_next = feed;
        end else if (IDX_I <= tail) begin
          value_next = left_val;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== hw/rtl/plist_chain.sv =====
// ----------------------------------------------------------------------------
// plist_chain
// Row of list cells with neighbor links, plus the read taps for the head,
// the tail and the slot picked by the target index.
// ----------------------------------------------------------------------------
module plist_chain
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int IW       = 4
) (
  input  logic                       clk,
  input  cell_op_t                   op,
  input  logic [IW-1:0]              tgt,
  input  logic [IW-1:0]              tail,
  input  logic signed [VALUE_W-1:0]  ins_val,
  output logic signed [VALUE_W-1:0]  head_val,
  output logic signed [VALUE_W-1:0]  tail_val,
  output logic signed [VALUE_W-1:0]  pick_val
);

  logic signed [VALUE_W-1:0] cells [CAPACITY];
  logic signed [VALUE_W-1:0] feed;

  always_comb begin
    unique case (op)
      CELL_ROT_LEFT:  feed = head_val;
      CELL_ROT_RIGHT: feed = tail_val;
      default:        feed = ins_val;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = feed;
    end else begin : g_mid_l
      assign left_val = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = feed;
    end else begin : g_mid_r
      assign right_val = cells[i+1];
    end

    plist_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .tgt       (tgt),
      .tail      (tail),
      .feed      (feed),
      .left_val  (left_val),
      .right_val (right_val),
      .value     (cells[i])
    );
  end

  assign head_val = cells[0];

  // One-hot AND-OR taps over the row.
  always_comb begin
    tail_val = '0;
    pick_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail == IW'(i)) begin
        tail_val = tail_val | cells[i];
      end
      if (tgt == IW'(i)) begin
        pick_val = pick_val | cells[i];
      end
    end
  end

endmodule

// ===== hw/rtl/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of up to CAPACITY signed values kept in a chain of cells that
// shift together. Inserts, deletes, unknown commands and empty dumps give
// one beat, registered in the cycle after the command is taken. A dump
// gives one beat per element from the dump state, one per cycle while the
// output register is free; a new command is taken once the last is loaded.
// Synchronous reset empties the list and clears the handshake; the slot
// values themselves are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value_in, [36:32] position, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value_out, [36:32] count, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW + 1) > POS_W) ? (CW + 1) : POS_W;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] remaining;
  logic [CW-1:0] remaining_next;
  logic          dump_rev;

  logic                      out_valid;
  status_t                   out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic [CW-1:0]             out_count;
  logic                      out_last;

  logic                      out_free;
  logic                      accept;
  cmd_t                      cmd;
  logic signed [VALUE_W-1:0] value_in;
  logic [POS_W-1:0]          position;
  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           cnt_ext;

  cell_op_t                  cell_op;
  logic [IW-1:0]             tgt;
  logic [IW-1:0]             tail;
  logic signed [VALUE_W-1:0] head_val;
  logic signed [VALUE_W-1:0] tail_val;
  logic signed [VALUE_W-1:0] pick_val;

  logic                      res_load;
  status_t                   res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_last;

  assign cmd      = cmd_t'(s_axis_tuser);
  assign value_in = s_axis_tdata[31:0];
  assign position = s_axis_tdata[36:32];
  assign pos_ext  = CMPW'(position);
  assign cnt_ext  = CMPW'(count);
  assign tail     = IW'(count - 1'b1);

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !rst && (state == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && count != '0 &&
            (cmd == CMD_DUMP_FWD || cmd == CMD_DUMP_REV)) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_free && remaining == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Chain control and result beat.
  always_comb begin
    cell_op        = CELL_HOLD;
    tgt            = '0;
    count_next     = count;
    remaining_next = remaining;
    res_load       = 1'b0;
    res_status     = STAT_OK;
    res_value      = '0;
    res_last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          priority case (cmd)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
              if (count == CW'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else if (cmd == CMD_INS_POS &&
                           (pos_ext == '0 || pos_ext > cnt_ext + 1'b1)) begin
                res_status = STAT_BADPOS;
              end else begin
                cell_op    = CELL_INSERT;
                count_next = count + 1'b1;
                if (cmd == CMD_INS_TAIL) begin
                  tgt = IW'(count);
                end else if (cmd == CMD_INS_POS) begin
                  tgt = IW'(position - 1'b1);
                end
              end
            end
            CMD_DELETE: begin
              tgt = IW'(position - 1'b1);
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                res_status = STAT_BADPOS;
              end else begin
                cell_op    = CELL_DELETE;
                res_value  = pick_val;
                count_next = count - 1'b1;
              end
            end
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                // Beats come from the dump state.
                res_load       = 1'b0;
                remaining_next = count;
              end
            end
            default: res_status = STAT_OK;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          res_load       = 1'b1;
          res_last       = (remaining == CW'(1));
          remaining_next = remaining - 1'b1;
          if (dump_rev) begin
            cell_op   = CELL_ROT_RIGHT;
            res_value = tail_val;
          end else begin
            cell_op   = CELL_ROT_LEFT;
            res_value = head_val;
          end
        end
      end
      default: cell_op = CELL_HOLD;
    endcase
  end

  plist_chain #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_chain (
    .clk      (clk),
    .op       (cell_op),
    .tgt      (tgt),
    .tail     (tail),
    .ins_val  (value_in),
    .head_val (head_val),
    .tail_val (tail_val),
    .pick_val (pick_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dump_rev <= (cmd == CMD_DUMP_REV);
    end
    if (res_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= count_next;
      out_last   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, COUNT_W'(out_count), out_value};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

// ===== tb/plist_checker.sv =====
// ----------------------------------------------------------------------------
// plist_checker
// Watches both stream channels of the positional list engine. Every accepted
// command beat is applied to a local copy of the list, which queues the result
// beats that the command must produce. Every accepted result beat is compared
// field by field with the oldest queued one, and each mismatch is counted.
// ----------------------------------------------------------------------------
module plist_checker
  import plist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value_in, [36:32] position, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] value_out, [36:32] count, rest zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          beats_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [4:0]  count;
    logic        last;
  } list_beat_t;

  list_beat_t  beats_due[$];
  logic [31:0] slot_q [CAPACITY];
  int          fill;

  function automatic void post_beat(status_t st, logic [31:0] v, logic lst);
    list_beat_t b;
    b.status = st;
    b.value  = v;
    b.count  = 5'(fill);
    b.last   = lst;
    beats_due.push_back(b);
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  task automatic apply_list_cmd(logic [2:0] op, logic [31:0] val, logic [4:0] pos);
    int          p;
    int          at;
    logic [31:0] removed;
    p = int'(pos);
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        // Fullness wins over a bad position.
        if (fill >= CAPACITY) begin
          post_beat(STAT_FULL, '0, 1'b1);
        end else if (op == CMD_INS_POS && (p < 1 || p > fill + 1)) begin
          post_beat(STAT_BADPOS, '0, 1'b1);
        end else begin
          at = (op == CMD_INS_HEAD) ? 0 : (op == CMD_INS_TAIL) ? fill : p - 1;
          for (int i = fill; i > at; i--) slot_q[i] = slot_q[i-1];
          slot_q[at] = val;
          fill++;
          post_beat(STAT_OK, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (fill == 0) begin
          post_beat(STAT_EMPTY, '0, 1'b1);
        end else if (p < 1 || p > fill) begin
          post_beat(STAT_BADPOS, '0, 1'b1);
        end else begin
          removed = slot_q[p-1];
          for (int i = p - 1; i + 1 < fill; i++) slot_q[i] = slot_q[i+1];
          fill--;
          post_beat(STAT_OK, removed, 1'b1);
        end
      end
      CMD_DUMP_FWD, CMD_DUMP_REV: begin
        if (fill == 0) begin
          post_beat(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < fill; k++) begin
            post_beat(STAT_OK, slot_q[(op == CMD_DUMP_FWD) ? k : fill - 1 - k],
                      k + 1 == fill);
          end
        end
      end
      default: begin
        post_beat(STAT_OK, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    list_beat_t want;
    if (rst) begin
      fill = 0;
      beats_due.delete();
    end else begin
      // Results are retired before the command of this edge is applied, since
      // a command never produces a beat on the edge that takes it.
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          $error("result beat with nothing expected: value_out %0h", m_axis_tdata[31:0]);
          mismatch_count++;
        end else begin
          want = beats_due.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("value_out", want.value, m_axis_tdata[31:0]);
          check_field("count", 32'(want.count), 32'(m_axis_tdata[36:32]));
          check_field("last", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_list_cmd(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32]);
      end
    end
    beats_waiting = beats_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the positional list engine: a short directed sequence over the
// empty, boundary and error cases, then random commands that alternate
// between filling and draining the list, under changing idle rates on both
// channels, long output stalls and full drains. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top
  import plist_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 260;
  localparam int LIMIT_CYCLES = 200000;

  // Command codes the block does not define; they must be answered anyway.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int   mismatch_count;
  int   beats_waiting;
  int   send_idle = 21;
  int   recv_idle = 46;
  int   items_sent = 0;
  int   cycles = 0;
  logic hold_off = 1'b0;
  int   hold_points[2] = '{60, 200};

  always #4 clk = ~clk;

  positional_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  plist_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatch_count(mismatch_count),
    .beats_waiting (beats_waiting)
  );

  // Offers one command beat and returns on the edge that accepts it. Reads
  // right after the edge see the values the block sampled there.
  task automatic send_item(input logic [2:0] op, input logic [31:0] val,
                           input logic [4:0] pos);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, val};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
  endtask

  // Even blocks of 30 commands lean toward inserts so the list reaches full,
  // odd blocks lean toward deletes so it runs empty again.
  task automatic send_random(input int n);
    logic [2:0]  op;
    logic [31:0] val;
    logic [4:0]  pos;
    int          r;
    int          q;
    bit          filling;
    filling = ((n / 30) % 2) == 0;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (r < 14) begin
      op = r[0] ? CMD_DUMP_REV : CMD_DUMP_FWD;
    end else if (r < (filling ? 80 : 40)) begin
      case ($urandom_range(0, 2))
        0:       op = CMD_INS_HEAD;
        1:       op = CMD_INS_TAIL;
        default: op = CMD_INS_POS;
      endcase
    end else begin
      op = CMD_DELETE;
    end
    q = $urandom_range(0, 99);
    if (q < 50)      pos = 5'($urandom_range(1, 4));
    else if (q < 80) pos = 5'($urandom_range(1, 17));
    else             pos = 5'($urandom_range(0, 31));
    q = $urandom_range(0, 99);
    case (q % 8)
      0:       val = (q < 12) ? 32'h7fff_ffff : $urandom;
      1:       val = (q < 12) ? 32'h8000_0000 : $urandom;
      2:       val = (q < 12) ? 32'hffff_ffff : $urandom;
      3:       val = (q < 12) ? 32'h0000_0000 : $urandom;
      default: val = $urandom;
    endcase
    send_item(op, val, pos);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Long output stalls while commands keep coming, so the block backs up.
  initial begin
    foreach (hold_points[h]) begin
      wait (items_sent >= hold_points[h]);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (150) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty list: dumps and delete report empty, inserts need position 1.
    send_item(CMD_DUMP_FWD, $urandom, 5'd1);
    send_item(CMD_DUMP_REV, $urandom, 5'd1);
    send_item(CMD_DELETE,   $urandom, 5'd1);
    send_item(CMD_INS_POS,  $urandom, 5'd0);
    send_item(CMD_INS_POS,  $urandom, 5'd2);
    send_item(CMD_INS_POS,  32'h7fff_ffff, 5'd1);
    send_item(CMD_INS_HEAD, 32'h8000_0000, 5'd31);
    send_item(CMD_INS_TAIL, 32'hffff_ffff, 5'd0);
    send_item(CMD_INS_POS,  32'h0000_0000, 5'd4);
    send_item(CMD_INS_POS,  $urandom, 5'd31);
    send_item(CMD_DUMP_FWD, $urandom, 5'd0);
    send_item(CMD_DUMP_REV, $urandom, 5'd31);
    send_item(CMD_DELETE,   $urandom, 5'd0);
    send_item(CMD_DELETE,   $urandom, 5'd5);
    send_item(CMD_DELETE,   $urandom, 5'd4);
    send_item(CMD_DELETE,   $urandom, 5'd1);
    send_item(CMD_SPARE_LO, $urandom, 5'($urandom));
    send_item(CMD_SPARE_HI, $urandom, 5'($urandom));
    send_item(CMD_INS_POS,  $urandom, 5'd2);
    send_item(CMD_DELETE,   $urandom, 5'd2);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle = 46;
        recv_idle = 21;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (i == RANDOM_ITEMS / 2) wait_drained();
      send_random(i);
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/plist_pkg.sv
hw/rtl/plist_cell.sv
hw/rtl/plist_chain.sv
hw/rtl/positional_list_engine_core.sv
tb/plist_checker.sv
tb/tb_top.sv
